### rtl/core/imhtq_pkg.sv
package imhtq_pkg;

   // widths fixed by the item fields
   localparam int TIME_W  = 48;
   localparam int ID_W    = 10;
   localparam int TOUT_W  = 31;
   localparam int WAIT_W  = 32;
   localparam int COUNT_W = 7;
   // heap position width, covers the largest supported capacity
   localparam int POS_W   = 6;
   localparam int ID_SPACE = 1024;

   // item kinds
   localparam logic [2:0] KIND_ADD    = 3'd0;
   localparam logic [2:0] KIND_FIRE   = 3'd1;
   localparam logic [2:0] KIND_ADJUST = 3'd2;
   localparam logic [2:0] KIND_EXPIRE = 3'd3;
   localparam logic [2:0] KIND_CLEAR  = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_BADID = 2'd2;

   typedef struct packed {
      logic [2:0]        kind;
      logic [ID_W-1:0]   timer_id;
      logic [TOUT_W-1:0] timeout_ms;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic                     fired_valid;
      logic [ID_W-1:0]          fired_id;
      logic [1:0]               status;
      logic signed [WAIT_W-1:0] next_wait_ms;
      logic [COUNT_W-1:0]       timer_count;
      logic                     last;
   } rsp_type;

   // one heap slot
   typedef struct packed {
      logic [TIME_W-1:0] expiry;
      logic [ID_W-1:0]   timer;
   } slot_type;

   // one slot write port
   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] addr;
      slot_type         data;
   } wr_port_type;

endpackage

### rtl/core/imhtq_cell.sv
module imhtq_cell #(
   parameter int IDX = 0
) (
   input  logic                   clock,
   input  imhtq_pkg::wr_port_type wr_a,
   input  imhtq_pkg::wr_port_type wr_b,
   output imhtq_pkg::slot_type    slot
);

   imhtq_pkg::slot_type slot_ff;
   imhtq_pkg::slot_type slot_in;

   // take a write addressed to this heap position
   always_comb begin
      slot_in = slot_ff;
      if (wr_a.en && wr_a.addr == imhtq_pkg::POS_W'(IDX)) begin
         slot_in = wr_a.data;
      end else if (wr_b.en && wr_b.addr == imhtq_pkg::POS_W'(IDX)) begin
         slot_in = wr_b.data;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;

endmodule

### rtl/core/imhtq_row.sv
module imhtq_row #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  imhtq_pkg::wr_port_type              wr_a,
   input  imhtq_pkg::wr_port_type              wr_b,
   input  logic [imhtq_pkg::POS_W-1:0]         rd_a_addr,
   input  logic [imhtq_pkg::POS_W-1:0]         rd_b_addr,
   input  logic [imhtq_pkg::COUNT_W-1:0]       occ,
   input  logic [imhtq_pkg::ID_W-1:0]          find_id,
   output imhtq_pkg::slot_type                 rd_a,
   output imhtq_pkg::slot_type                 rd_b,
   output imhtq_pkg::slot_type                 root,
   output logic                                hit,
   output logic [imhtq_pkg::POS_W-1:0]         hit_pos
);

   imhtq_pkg::slot_type slots [CAPACITY];
   imhtq_pkg::slot_type rd_a_ff, rd_a_in;
   imhtq_pkg::slot_type rd_b_ff, rd_b_in;

   // row of heap cells, one per position
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      imhtq_cell #(.IDX(k)) u_cell (
         .clock (clock),
         .wr_a  (wr_a),
         .wr_b  (wr_b),
         .slot  (slots[k])
      );
   end

   // registered read selection across all cells, id match across the occupied cells
   always_comb begin
      rd_a_in = '0;
      rd_b_in = '0;
      hit     = 1'b0;
      hit_pos = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if (rd_a_addr == imhtq_pkg::POS_W'(k)) begin
            rd_a_in = rd_a_in | slots[k];
         end
         if (rd_b_addr == imhtq_pkg::POS_W'(k)) begin
            rd_b_in = rd_b_in | slots[k];
         end
         if (imhtq_pkg::COUNT_W'(k) < occ && slots[k].timer == find_id) begin
            hit     = 1'b1;
            hit_pos = hit_pos | imhtq_pkg::POS_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= rd_a_in;
      rd_b_ff <= rd_b_in;
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;
   assign root = slots[0];

endmodule

### rtl/core/indexed_min_heap_timer_queue.sv
// channel  ports                              direction
// request  req_valid, req_stall, req_payload  in  (kind, timer_id, timeout_ms, now_ms)
// response rsp_valid, rsp_stall, rsp_payload  out (fired, id, status, wait, count, last)
//
// one item at a time: a lookup, a removal (read and write), a read and a compare per heap level
// sifted (at most log2(CAPACITY)-1 levels) and a load of the response
// expire gives one response per due timer, each costing one removal, or one response if none is due
// reset clears occupancy and control; heap cells hold no reset value
// a response waits in the output register while rsp_stall is high; the next
// request is taken as soon as the last response of an item is registered
module indexed_min_heap_timer_queue #(
   parameter int CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  imhtq_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output imhtq_pkg::rsp_type  rsp_payload
);

   localparam int PW = imhtq_pkg::POS_W;
   localparam int CW = imhtq_pkg::COUNT_W;
   localparam int TW = imhtq_pkg::TIME_W;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_LOOK   = 10'b0000000010,
      S_EXP    = 10'b0000000100,
      S_RM_RD  = 10'b0000001000,
      S_RM_WR  = 10'b0000010000,
      S_DN_RD  = 10'b0000100000,
      S_DN_CMP = 10'b0001000000,
      S_UP_RD  = 10'b0010000000,
      S_UP_CMP = 10'b0100000000,
      S_EMIT   = 10'b1000000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CW-1:0]                   occ_ff, occ_in;
   logic [2:0]                      kind_ff, kind_in;
   logic [imhtq_pkg::ID_W-1:0]      id_ff, id_in;
   logic [TW-1:0]                   now_ff, now_in;
   logic [TW-1:0]                   exp_ff, exp_in;
   imhtq_pkg::slot_type             cur_ff, cur_in;
   logic [PW-1:0]                   pos_ff, pos_in;
   logic                            moved_ff, moved_in;
   logic                            up_after_ff, up_after_in;
   logic                            fired_ff, fired_in;
   logic [imhtq_pkg::ID_W-1:0]      fid_ff, fid_in;
   logic [1:0]                      status_ff, status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   imhtq_pkg::rsp_type              rsp_payload_ff, rsp_payload_in;

   imhtq_pkg::wr_port_type          wr_a, wr_b;
   logic [PW-1:0]                   rd_a_addr, rd_b_addr;
   imhtq_pkg::slot_type             rd_a, rd_b, root;
   logic                            hit;
   logic [PW-1:0]                   hit_pos;

   logic                            accept;
   logic [TW:0]                     sum;
   logic                            id_ok, due;
   logic [PW+1:0]                   c_left, c_right, occ_wide;
   logic [PW-1:0]                   pos_m1, parent;
   logic                            take_right;
   imhtq_pkg::slot_type             child;
   logic [PW-1:0]                   child_pos;
   logic [TW-1:0]                   diff;
   logic [imhtq_pkg::WAIT_W-1:0]    wait_ms;
   logic                            last;

   imhtq_row #(.CAPACITY(CAPACITY)) u_row (
      .clock     (clock),
      .wr_a      (wr_a),
      .wr_b      (wr_b),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .occ       (occ_ff),
      .find_id   (id_ff),
      .rd_a      (rd_a),
      .rd_b      (rd_b),
      .root      (root),
      .hit       (hit),
      .hit_pos   (hit_pos)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // heap position arithmetic
   assign c_left   = {1'b0, pos_ff, 1'b1};
   assign c_right  = c_left + 1'b1;
   assign occ_wide = (PW + 2)'(occ_ff);
   assign pos_m1   = pos_ff - 1'b1;
   assign parent   = {1'b0, pos_m1[PW-1:1]};
   assign take_right = (c_right < occ_wide) && (rd_b.expiry < rd_a.expiry);
   assign child      = take_right ? rd_b : rd_a;
   assign child_pos  = take_right ? c_right[PW-1:0] : c_left[PW-1:0];

   assign sum   = {1'b0, req_payload.now_ms} + (TW + 1)'(req_payload.timeout_ms);
   assign id_ok = (17'(id_ff) < 17'(imhtq_pkg::ID_SPACE));
   assign due   = (occ_ff != '0) && (root.expiry <= now_ff);

   // wait until the earliest expiry, floored at zero and saturated; all ones when the heap is empty
   always_comb begin
      diff    = root.expiry - now_ff;
      wait_ms = '1;
      if (occ_ff != '0) begin
         if (root.expiry <= now_ff) begin
            wait_ms = '0;
         end else if (diff > TW'(32'h7FFF_FFFF)) begin
            wait_ms = 32'h7FFF_FFFF;
         end else begin
            wait_ms = diff[imhtq_pkg::WAIT_W-1:0];
         end
      end
   end

   assign last = !(fired_ff && kind_ff == imhtq_pkg::KIND_EXPIRE && due);

   // read port addresses
   always_comb begin
      rd_a_addr = c_left[PW-1:0];
      rd_b_addr = c_right[PW-1:0];
      if (state_ff == S_UP_RD) begin
         rd_a_addr = parent;
      end else if (state_ff == S_RM_RD) begin
         rd_a_addr = occ_ff[PW-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      occ_in         = occ_ff;
      kind_in        = kind_ff;
      id_in          = id_ff;
      now_in         = now_ff;
      exp_in         = exp_ff;
      cur_in         = cur_ff;
      pos_in         = pos_ff;
      moved_in       = moved_ff;
      up_after_in    = up_after_ff;
      fired_in       = fired_ff;
      fid_in         = fid_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      wr_a           = '0;
      wr_b           = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in   = req_payload.kind;
               id_in     = req_payload.timer_id;
               now_in    = req_payload.now_ms;
               exp_in    = sum[TW] ? '1 : sum[TW-1:0];
               fired_in  = 1'b0;
               status_in = imhtq_pkg::STATUS_OK;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_EMIT;
            unique case (kind_ff) inside
               imhtq_pkg::KIND_ADD, imhtq_pkg::KIND_ADJUST: begin
                  if (!id_ok || (kind_ff == imhtq_pkg::KIND_ADJUST && !hit)) begin
                     status_in = imhtq_pkg::STATUS_BADID;
                  end else if (hit) begin
                     // refresh in place, then resettle
                     cur_in      = '{expiry: exp_ff, timer: id_ff};
                     wr_a        = '{en: 1'b1, addr: hit_pos, data: cur_in};
                     pos_in      = hit_pos;
                     moved_in    = 1'b0;
                     up_after_in = 1'b1;
                     state_in    = S_DN_RD;
                  end else if (occ_ff >= CW'(CAPACITY)) begin
                     status_in = imhtq_pkg::STATUS_FULL;
                  end else begin
                     // append at the end and sift up
                     cur_in   = '{expiry: exp_ff, timer: id_ff};
                     wr_a     = '{en: 1'b1, addr: occ_ff[PW-1:0], data: cur_in};
                     pos_in   = occ_ff[PW-1:0];
                     occ_in   = occ_ff + 1'b1;
                     state_in = S_UP_RD;
                  end
               end
               imhtq_pkg::KIND_FIRE: begin
                  if (!id_ok) begin
                     status_in = imhtq_pkg::STATUS_BADID;
                  end else if (hit) begin
                     fired_in = 1'b1;
                     fid_in   = id_ff;
                     occ_in   = occ_ff - 1'b1;
                     pos_in   = hit_pos;
                     if (CW'(hit_pos) < occ_ff - 1'b1) begin
                        state_in = S_RM_RD;
                     end
                  end
               end
               imhtq_pkg::KIND_EXPIRE: begin
                  state_in = S_EXP;
               end
               imhtq_pkg::KIND_CLEAR: begin
                  occ_in = '0;
               end
               default: begin
                  state_in = S_EMIT;
               end
            endcase
         end
         S_EXP: begin
            // remove the root if due
            state_in = S_EMIT;
            fired_in = due;
            if (due) begin
               fid_in = root.timer;
               occ_in = occ_ff - 1'b1;
               pos_in = '0;
               if (occ_ff > CW'(1)) begin
                  state_in = S_RM_RD;
               end
            end
         end
         S_RM_RD: begin
            state_in = S_RM_WR;
         end
         S_RM_WR: begin
            // last entry fills the hole
            cur_in      = rd_a;
            wr_a        = '{en: 1'b1, addr: pos_ff, data: rd_a};
            moved_in    = 1'b0;
            up_after_in = 1'b1;
            state_in    = S_DN_RD;
         end
         S_DN_RD: begin
            if (c_left >= occ_wide) begin
               state_in = (!moved_ff && up_after_ff) ? S_UP_RD : S_EMIT;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (cur_ff.expiry < child.expiry) begin
               state_in = (!moved_ff && up_after_ff) ? S_UP_RD : S_EMIT;
            end else begin
               wr_a     = '{en: 1'b1, addr: pos_ff, data: child};
               wr_b     = '{en: 1'b1, addr: child_pos, data: cur_ff};
               pos_in   = child_pos;
               moved_in = 1'b1;
               state_in = S_DN_RD;
            end
         end
         S_UP_RD: begin
            state_in = (pos_ff == '0) ? S_EMIT : S_UP_CMP;
         end
         S_UP_CMP: begin
            if (rd_a.expiry < cur_ff.expiry) begin
               state_in = S_EMIT;
            end else begin
               wr_a     = '{en: 1'b1, addr: pos_ff, data: rd_a};
               wr_b     = '{en: 1'b1, addr: parent, data: cur_ff};
               pos_in   = parent;
               state_in = S_UP_RD;
            end
         end
         S_EMIT: begin
            // load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.fired_valid  = fired_ff;
               rsp_payload_in.fired_id     = fired_ff ? fid_ff : '0;
               rsp_payload_in.status       = status_ff;
               rsp_payload_in.next_wait_ms = wait_ms;
               rsp_payload_in.timer_count  = occ_ff;
               rsp_payload_in.last         = last;
               state_in                    = last ? S_IDLE : S_EXP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      id_ff          <= id_in;
      now_ff         <= now_in;
      exp_ff         <= exp_in;
      cur_ff         <= cur_in;
      pos_ff         <= pos_in;
      moved_ff       <= moved_in;
      up_after_ff    <= up_after_in;
      fired_ff       <= fired_in;
      fid_ff         <= fid_in;
      status_ff      <= status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // occupancy stays within the heap
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(CAPACITY))
      else $error("occupancy beyond capacity");

   // an accepted request always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_LOOK)
      else $error("request accepted without lookup");

   // a response without a fired timer carries no id
   a_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.fired_valid || rsp_payload_ff.fired_id == '0))
      else $error("stray fired id");

   // a response that is not last must name a fired timer
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_payload_ff.last) |-> rsp_payload_ff.fired_valid)
      else $error("non-final response without fired timer");

endmodule

### sim/tb_indexed_min_heap_timer_queue.sv
module tb_indexed_min_heap_timer_queue;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HEAP_SLOTS = 64;
   localparam int TW = imhtq_pkg::TIME_W;
   localparam int IW = imhtq_pkg::ID_W;
   localparam logic [TW-1:0] TIME_TOP = {TW{1'b1}};
   localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
   localparam logic [2:0] KIND_SPARE_MID = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   imhtq_pkg::req_type req_payload;
   logic               rsp_valid;
   logic               rsp_stall;
   imhtq_pkg::rsp_type rsp_payload;

   indexed_min_heap_timer_queue u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // clock and time limit
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   // timer heap mirror
   logic [TW-1:0]     heap_expiry[HEAP_SLOTS];
   logic [IW-1:0]     heap_timer[HEAP_SLOTS];
   int unsigned       slot_of_timer[imhtq_pkg::ID_SPACE];
   bit                timer_held[imhtq_pkg::ID_SPACE];
   int unsigned       held_count;

   imhtq_pkg::rsp_type due_rsps[$];
   int                 mismatch_count;
   int                 hold_cycles;
   bit                 quiet_receiver;
   bit                 quiet_sender;

   typedef struct {
      imhtq_pkg::req_type q;
      bit                 typed;
      imhtq_pkg::rsp_type r;
   } step_type;

   step_type           steps[$];
   int                 pin_idx;

   function automatic void swap_slots(int unsigned a, int unsigned b);
      logic [TW-1:0] e;
      logic [IW-1:0] t;
      e = heap_expiry[a];
      t = heap_timer[a];
      heap_expiry[a] = heap_expiry[b];
      heap_timer[a] = heap_timer[b];
      heap_expiry[b] = e;
      heap_timer[b] = t;
      slot_of_timer[heap_timer[a]] = a;
      slot_of_timer[heap_timer[b]] = b;
   endfunction

   function automatic bit rise(int unsigned i);
      int unsigned start;
      int unsigned p;
      start = i;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (heap_expiry[p] < heap_expiry[i]) break;
         swap_slots(i, p);
         i = p;
      end
      return i != start;
   endfunction

   function automatic bit sink(int unsigned i, int unsigned n);
      int unsigned start;
      int unsigned c;
      start = i;
      c = 2 * i + 1;
      while (c < n) begin
         if (c + 1 < n && heap_expiry[c+1] < heap_expiry[c]) c++;
         if (heap_expiry[i] < heap_expiry[c]) break;
         swap_slots(i, c);
         i = c;
         c = 2 * i + 1;
      end
      return i != start;
   endfunction

   function automatic void resettle(int unsigned i, int unsigned n);
      if (!sink(i, n)) void'(rise(i));
   endfunction

   function automatic void remove_slot(int unsigned i);
      int unsigned n;
      n = held_count - 1;
      if (i < n) begin
         swap_slots(i, n);
         resettle(i, n);
      end
      timer_held[heap_timer[n]] = 1'b0;
      held_count = n;
   endfunction

   function automatic void push_result(logic fired, logic [IW-1:0] id, logic [1:0] st,
                                       logic [TW-1:0] now);
      imhtq_pkg::rsp_type r;
      logic [TW-1:0] w;
      r = '0;
      r.fired_valid = fired;
      r.fired_id = fired ? id : '0;
      r.status = st;
      if (held_count == 0) begin
         r.next_wait_ms = -1;
      end else begin
         w = (heap_expiry[0] > now) ? heap_expiry[0] - now : '0;
         r.next_wait_ms = (w > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : w[imhtq_pkg::WAIT_W-1:0];
      end
      r.timer_count = held_count[imhtq_pkg::COUNT_W-1:0];
      due_rsps.insert(due_rsps.size(), r);
   endfunction

   // work out the results of one accepted item
   function automatic void predict_timer_op(imhtq_pkg::req_type q);
      logic [TW:0]   sum;
      logic [TW-1:0] expiry;
      logic [IW-1:0] t;
      int unsigned   i;
      int            first;
      first = due_rsps.size();
      sum = {1'b0, q.now_ms} + (TW + 1)'(q.timeout_ms);
      expiry = sum[TW] ? TIME_TOP : sum[TW-1:0];
      case (q.kind)
         imhtq_pkg::KIND_ADD: begin
            if (timer_held[q.timer_id]) begin
               i = slot_of_timer[q.timer_id];
               heap_expiry[i] = expiry;
               resettle(i, held_count);
               push_result(1'b0, '0, imhtq_pkg::STATUS_OK, q.now_ms);
            end else if (held_count >= HEAP_SLOTS) begin
               push_result(1'b0, '0, imhtq_pkg::STATUS_FULL, q.now_ms);
            end else begin
               i = held_count++;
               heap_expiry[i] = expiry;
               heap_timer[i] = q.timer_id;
               slot_of_timer[q.timer_id] = i;
               timer_held[q.timer_id] = 1'b1;
               void'(rise(i));
               push_result(1'b0, '0, imhtq_pkg::STATUS_OK, q.now_ms);
            end
         end
         imhtq_pkg::KIND_FIRE: begin
            if (timer_held[q.timer_id]) begin
               remove_slot(slot_of_timer[q.timer_id]);
               push_result(1'b1, q.timer_id, imhtq_pkg::STATUS_OK, q.now_ms);
            end else begin
               push_result(1'b0, '0, imhtq_pkg::STATUS_OK, q.now_ms);
            end
         end
         imhtq_pkg::KIND_ADJUST: begin
            if (timer_held[q.timer_id]) begin
               i = slot_of_timer[q.timer_id];
               heap_expiry[i] = expiry;
               resettle(i, held_count);
               push_result(1'b0, '0, imhtq_pkg::STATUS_OK, q.now_ms);
            end else begin
               push_result(1'b0, '0, imhtq_pkg::STATUS_BADID, q.now_ms);
            end
         end
         imhtq_pkg::KIND_EXPIRE: begin
            while (held_count > 0 && heap_expiry[0] <= q.now_ms) begin
               t = heap_timer[0];
               remove_slot(0);
               push_result(1'b1, t, imhtq_pkg::STATUS_OK, q.now_ms);
            end
            if (due_rsps.size() == first)
               push_result(1'b0, '0, imhtq_pkg::STATUS_OK, q.now_ms);
         end
         imhtq_pkg::KIND_CLEAR: begin
            foreach (timer_held[k]) timer_held[k] = 1'b0;
            held_count = 0;
            push_result(1'b0, '0, imhtq_pkg::STATUS_OK, q.now_ms);
         end
         default: push_result(1'b0, '0, imhtq_pkg::STATUS_OK, q.now_ms);
      endcase
      due_rsps[due_rsps.size()-1].last = 1'b1;
   endfunction

   // request transfers feed the mirror, response transfers are checked
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_timer_op(req_payload);
         // directed rows with a typed result override the prediction
         if (pin_idx < steps.size()) begin
            if (steps[pin_idx].typed) due_rsps[due_rsps.size()-1] = steps[pin_idx].r;
            pin_idx++;
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %p", rsp_payload);
         end else begin
            if (rsp_payload !== due_rsps[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch: expected %p got %p", due_rsps[0], rsp_payload);
            end
            void'(due_rsps.pop_front());
         end
      end
   end

   // receiver: random stall before each transfer, long hold when asked
   initial begin
      int n;
      bit got;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
         end else begin
            n = quiet_receiver ? 0 : $urandom_range(0, 13);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do begin
            @(negedge clock);
            got = rsp_valid;
            @(posedge clock);
         end while (!got);
      end
   end

   task automatic send_item(imhtq_pkg::req_type q);
      int  gap;
      bit  taken;
      gap = quiet_sender ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= q;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (due_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic imhtq_pkg::req_type make_item(logic [2:0] kind, logic [IW-1:0] id,
                                                    logic [imhtq_pkg::TOUT_W-1:0] tout,
                                                    logic [TW-1:0] now);
      imhtq_pkg::req_type q;
      q.kind = kind;
      q.timer_id = id;
      q.timeout_ms = tout;
      q.now_ms = now;
      return q;
   endfunction

   function automatic void add_step(imhtq_pkg::req_type q, bit typed, imhtq_pkg::rsp_type r);
      step_type s;
      s.q = q;
      s.typed = typed;
      s.r = r;
      steps.insert(steps.size(), s);
   endfunction

   logic [TW-1:0]                now;
   logic [2:0]                   kind;
   logic [IW-1:0]                id;
   logic [imhtq_pkg::TOUT_W-1:0] tout;
   int                           pick;
   imhtq_pkg::rsp_type           idle_rsp;

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      mismatch_count = 0;
      pin_idx = 0;
      hold_cycles = 0;
      quiet_receiver = 1'b0;
      quiet_sender = 1'b0;
      held_count = 0;
      foreach (timer_held[k]) timer_held[k] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed steps
      idle_rsp = '{fired_valid: 1'b0, fired_id: '0, status: imhtq_pkg::STATUS_OK,
                   next_wait_ms: -1, timer_count: '0, last: 1'b1};
      add_step(make_item(imhtq_pkg::KIND_EXPIRE, 10'd0, '0, 48'd0), 1'b1, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_FIRE, 10'd5, '0, 48'd7), 1'b1, idle_rsp);
      idle_rsp.status = imhtq_pkg::STATUS_BADID;
      add_step(make_item(imhtq_pkg::KIND_ADJUST, 10'd1023, '1, TIME_TOP), 1'b1, idle_rsp);
      idle_rsp.status = imhtq_pkg::STATUS_OK;
      idle_rsp.next_wait_ms = 0;
      idle_rsp.timer_count = 7'd1;
      // saturated expiry at the top of time
      add_step(make_item(imhtq_pkg::KIND_ADD, 10'd0, '1, TIME_TOP), 1'b1, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_CLEAR, 10'd0, '0, 48'd0), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_ADD, 10'd1023, '1, 48'd0), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_ADD, 10'd1, 31'd50, 48'd10), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_ADD, 10'd2, 31'd50, 48'd10), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_ADD, 10'd3, 31'd50, 48'd10), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_ADD, 10'd4, 31'd20, 48'd10), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_ADD, 10'd1, 31'd5, 48'd12), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_ADJUST, 10'd4, 31'd900, 48'd12), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_ADJUST, 10'd1023, 31'd1, 48'd12), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_FIRE, 10'd2, '0, 48'd13), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_FIRE, 10'd2, '0, 48'd13), 1'b0, idle_rsp);
      add_step(make_item(KIND_SPARE_LO, 10'd9, '1, 48'd14), 1'b0, idle_rsp);
      add_step(make_item(KIND_SPARE_MID, 10'd9, 31'd3, 48'd14), 1'b0, idle_rsp);
      add_step(make_item(KIND_SPARE_HI, 10'd9, 31'd3, 48'd14), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_EXPIRE, 10'd0, '0, 48'd60), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_EXPIRE, 10'd0, '0, 48'd61), 1'b0, idle_rsp);
      add_step(make_item(imhtq_pkg::KIND_EXPIRE, 10'd0, '0, TIME_TOP), 1'b0, idle_rsp);
      idle_rsp.next_wait_ms = -1;
      idle_rsp.timer_count = '0;
      add_step(make_item(imhtq_pkg::KIND_CLEAR, 10'd0, '0, TIME_TOP), 1'b1, idle_rsp);
      foreach (steps[s]) begin
         send_item(steps[s].q);
      end
      req_valid <= 1'b0;
      wait_drained();

      // back pressure: a long receiver hold, then the heap fills past capacity
      hold_cycles = 400;
      quiet_sender = 1'b1;
      for (int k = 0; k < HEAP_SLOTS + 2; k++)
         send_item(make_item(imhtq_pkg::KIND_ADD, 10'(k * 13 + 100),
                             31'($urandom_range(0, 3000)), 48'd1000));
      send_item(make_item(imhtq_pkg::KIND_EXPIRE, 10'd0, '0, 48'd2500));
      send_item(make_item(imhtq_pkg::KIND_EXPIRE, 10'd0, '0, 48'd9000));
      quiet_sender = 1'b0;
      req_valid <= 1'b0;
      wait_drained();

      // random traffic around a drifting clock
      now = 48'd5000;
      for (int k = 0; k < 20; k++) begin
         quiet_receiver = (k >= 6 && k < 12);
         quiet_sender = (k >= 8 && k < 12);
         pick = $urandom_range(0, 99);
         kind = pick < 45 ? imhtq_pkg::KIND_ADD : pick < 60 ? imhtq_pkg::KIND_FIRE :
                pick < 75 ? imhtq_pkg::KIND_ADJUST : pick < 94 ? imhtq_pkg::KIND_EXPIRE :
                pick < 97 ? imhtq_pkg::KIND_CLEAR :
                3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
         id = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 15)) : 10'($urandom);
         tout = ($urandom_range(0, 9) < 6) ? 31'($urandom_range(0, 120)) : 31'($urandom);
         if ($urandom_range(0, 19) == 0) now = 48'({$urandom, $urandom});
         else now = 48'(now + 48'($urandom_range(0, 40)));
         send_item(make_item(kind, id, tout, now));
      end
      req_valid <= 1'b0;
      quiet_receiver = 1'b0;
      quiet_sender = 1'b0;
      wait_drained();

      if (mismatch_count == 0 && due_rsps.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/imhtq_pkg.sv
rtl/core/imhtq_cell.sv
rtl/core/imhtq_row.sv
rtl/core/indexed_min_heap_timer_queue.sv
sim/tb_indexed_min_heap_timer_queue.sv
